// File: hdl/fbfl_pkg.sv
// fbfl_pkg: shared types, codes and defaults for the fixed block free list
// no dependencies

package fbfl_pkg;

    localparam int NUM_BLOCKS_DEF      = 256;
    localparam int MAX_BLOCK_BYTES_DEF = 4096;
    localparam int POOL_MAX            = 256;

    localparam logic [8:0] LINK_NIL  = 9'h100;
    localparam logic [8:0] CNT_MAX   = 9'h1FF;
    localparam logic [8:0] BC_RESET  = 9'd256;
    localparam logic [12:0] BB_RESET = 13'd8;

    localparam logic [1:0] CFG_BLOCK_COUNT = 2'd0;
    localparam logic [1:0] CFG_BLOCK_BYTES = 2'd1;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_BUILD,
        ST_IDLE,
        ST_POP
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [7:0]  block_index;
        logic [19:0] block_offset;
        logic [8:0]  used_count;
        logic [8:0]  available_count;
    } t_result;

endpackage

// File: hdl/fbfl_ram.sv
// fbfl_ram: generic single write port, single read port ram, registered read
// no dependencies

module fbfl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/fbfl_ctrl.sv
// fbfl_ctrl: free list controller, config registers, head and counters
// depends on fbfl_pkg and fbfl_ram (link memory)

module fbfl_ctrl #(
    parameter int NUM_BLOCKS      = fbfl_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_BLOCK_BYTES = fbfl_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_req_type,
    input  logic [7:0]        i_free_index,
    output logic              o_in_stall,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [12:0]       i_cfg_data,
    output logic              o_cfg_ready,
    input  logic              i_q_full,
    output logic              o_push,
    output fbfl_pkg::t_result o_push_data
);

    import fbfl_pkg::*;

    localparam int LINK_DEPTH = (NUM_BLOCKS < POOL_MAX) ? NUM_BLOCKS : POOL_MAX;
    localparam int AW         = $clog2(LINK_DEPTH);
    localparam int SW         = $clog2(MAX_BLOCK_BYTES + 8);

    t_state r_state, n_state;

    logic [8:0]            r_bc;
    logic [12:0]           r_bb;
    logic [8:0]            r_pool;
    logic [SW-1:0]         r_size;
    logic [8:0]            r_head;
    logic [8:0]            r_used;
    logic [LINK_DEPTH-1:0] r_lvalid;
    logic                  r_rd_valid;
    logic [AW-1:0]         r_rd_addr;

    logic [8:0]    pool_n;
    logic [31:0]   sat_bytes;
    logic [31:0]   rnd_bytes;
    logic [SW-1:0] size_n;
    logic          cfg_wr;
    logic          cfg_hit;
    logic          accept;
    logic          is_alloc;
    logic          range_bad;
    logic [31:0]   prod;
    logic [8:0]    used_inc;
    logic [8:0]    used_dec;
    logic [8:0]    used_nxt;
    t_result       res;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [8:0]    mem_rdata;
    logic [8:0]    link_out;

    // pool size and rounded block size
    always_comb begin
        pool_n    = ({23'b0, r_bc} < 32'(LINK_DEPTH)) ? r_bc : 9'(LINK_DEPTH);
        sat_bytes = ({19'b0, r_bb} > 32'(MAX_BLOCK_BYTES)) ? 32'(MAX_BLOCK_BYTES)
                                                          : {19'b0, r_bb};
        rnd_bytes = (sat_bytes + 32'd7) & ~32'd7;
        if (rnd_bytes < 32'd8) begin
            rnd_bytes = 32'd8;
        end
        size_n = SW'(rnd_bytes);
    end

    assign cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign cfg_hit   = cfg_wr && (i_cfg_index == CFG_BLOCK_COUNT ||
                                  i_cfg_index == CFG_BLOCK_BYTES);
    assign accept    = i_in_valid && !o_in_stall;
    assign is_alloc  = (i_req_type == REQ_ALLOC);
    assign range_bad = ({1'b0, i_free_index} >= r_pool);
    assign prod      = 32'(r_head[7:0]) * 32'(r_size);
    assign used_inc  = (r_used == CNT_MAX) ? r_used : r_used + 9'd1;
    assign used_dec  = (r_used == 9'd0) ? r_used : r_used - 9'd1;

    always_comb begin
        res.status       = STS_OK;
        res.block_index  = 8'd0;
        res.block_offset = 20'd0;
        used_nxt         = r_used;
        if (is_alloc) begin
            if (r_head[8]) begin
                res.status = STS_EMPTY;
            end else begin
                res.block_index  = r_head[7:0];
                res.block_offset = prod[19:0];
                used_nxt         = used_inc;
            end
        end else begin
            if (range_bad) begin
                res.status = STS_RANGE;
            end else begin
                used_nxt = used_dec;
            end
        end
        res.used_count      = used_nxt;
        res.available_count = (used_nxt >= r_pool) ? 9'd0 : r_pool - used_nxt;
    end

    assign o_push      = accept;
    assign o_push_data = res;

    // link memory access
    assign mem_we    = accept && !is_alloc && !range_bad;
    assign mem_waddr = i_free_index[AW-1:0];
    assign mem_re    = accept && is_alloc && !r_head[8];
    assign mem_raddr = r_head[AW-1:0];

    // entries not written since rebuild link to index minus one
    assign link_out = r_rd_valid ? mem_rdata :
                      (r_rd_addr == '0) ? LINK_NIL : {1'b0, 8'(r_rd_addr - 1'b1)};

    fbfl_ram #(
        .WIDTH (9),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_head),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        case (r_state)
            ST_BUILD: n_state = cfg_hit ? ST_BUILD : ST_IDLE;
            ST_IDLE: begin
                if (cfg_hit) begin
                    n_state = ST_BUILD;
                end else if (mem_re) begin
                    n_state = ST_POP;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_POP:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != ST_IDLE) || i_q_full;
        o_cfg_ready = (r_state != ST_POP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_BUILD;
            r_bc     <= BC_RESET;
            r_bb     <= BB_RESET;
            r_used   <= 9'd0;
            r_lvalid <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr && i_cfg_index == CFG_BLOCK_COUNT) begin
                r_bc <= i_cfg_data[8:0];
            end
            if (cfg_wr && i_cfg_index == CFG_BLOCK_BYTES) begin
                r_bb <= i_cfg_data;
            end
            if (cfg_hit) begin
                r_lvalid <= '0;
                r_used   <= 9'd0;
            end else if (accept) begin
                r_used <= used_nxt;
                if (mem_we) begin
                    r_lvalid[mem_waddr] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_BUILD) begin
            r_pool <= pool_n;
            r_size <= size_n;
            r_head <= (pool_n == 9'd0) ? LINK_NIL : {1'b0, 8'(pool_n - 9'd1)};
        end else if (r_state == ST_POP) begin
            r_head <= link_out;
        end else if (mem_we) begin
            r_head <= {1'b0, i_free_index};
        end
        if (mem_re) begin
            r_rd_valid <= r_lvalid[mem_raddr];
            r_rd_addr  <= mem_raddr;
        end
    end

`ifndef SYNTHESIS
    a_pop_after_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_POP |-> $past(accept && is_alloc && !r_head[8]))
        else $error("pop cycle without an allocate transfer");

    a_no_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !o_push && !mem_we)
        else $error("transfer taken while list is busy");

    a_head_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !r_head[8]) |-> ({1'b0, r_head[7:0]} < r_pool))
        else $error("free list head outside pool");
`endif

endmodule

// File: hdl/fbfl_out_fifo.sv
// fbfl_out_fifo: two entry result queue between controller and output port
// depends on fbfl_pkg

module fbfl_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fbfl_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output fbfl_pkg::t_result o_data
);

    import fbfl_pkg::*;

    t_result    r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("result pushed into full queue");
`endif

endmodule

// File: hdl/fixed_block_free_list_top.sv
// Fixed-size block pool kept as a last-in first-out free list in a link memory.
// An allocate returns the head block at once and reads the next head from
// the link memory in the following cycle, while new transfers stall. A free
// links the freed block in as the new head. Results go into a two entry queue, so
// input transfers continue while a result waits on the output. Writing
// block_count or block_bytes rebuilds the pool; link entries not written since
// the rebuild read as index minus one through per-entry valid bits. Out-of-range
// frees return status 2 and change nothing; double frees are not detected.
// depends on fbfl_pkg, fbfl_ctrl, fbfl_out_fifo

module fixed_block_free_list_top #(
    parameter int NUM_BLOCKS      = fbfl_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_BLOCK_BYTES = fbfl_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_free_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_block_index,
    output logic [19:0] o_block_offset,
    output logic [8:0]  o_used_count,
    output logic [8:0]  o_available_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    import fbfl_pkg::*;

    logic    q_full;
    logic    push;
    t_result push_data;
    t_result out_data;

    fbfl_ctrl #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_req_type   (i_req_type),
        .i_free_index (i_free_index),
        .o_in_stall   (o_stall),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    fbfl_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (out_data)
    );

    assign o_status          = out_data.status;
    assign o_block_index     = out_data.block_index;
    assign o_block_offset    = out_data.block_offset;
    assign o_used_count      = out_data.used_count;
    assign o_available_count = out_data.available_count;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// testbench for fixed_block_free_list_top: directed table then random alloc/free transfers,
// each result checked field by field against a free list kept in the testbench
// depends on fbfl_pkg and fixed_block_free_list_top

module testbench;
    import fbfl_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES = 8;
    localparam int PH_COUNT [PHASES] = '{16, 256, 1, 0, 5, 300, 1, 32};
    localparam int PH_BYTES [PHASES] = '{64, 4096, 1, 4095, 100, 8191, 8, 512};
    localparam int PH_ITEMS [PHASES] = '{250, 250, 150, 60, 250, 250, 600, 250};
    localparam int STORM_PHASE = 6;
    localparam int HOLD_PHASE = 4;

    typedef enum logic {ROW_REQ, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        req;
        logic [7:0]  idx;
        logic [1:0]  reg_idx;
        logic [12:0] reg_data;
        bit          typed;
        t_result     want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_req_type = REQ_ALLOC;
    logic [7:0]  i_free_index = 8'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_block_index;
    logic [19:0] o_block_offset;
    logic [8:0]  o_used_count;
    logic [8:0]  o_available_count;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_BLOCK_COUNT;
    logic [12:0] i_cfg_data = 13'd0;

    logic [8:0]  link_mem [POOL_MAX];
    logic [8:0]  list_head;
    logic [8:0]  used_blocks;
    logic [8:0]  count_reg;
    logic [12:0] bytes_reg;
    logic [7:0]  held_blocks [$];
    t_result     owed_results [$];
    t_result     due;

    int mismatches = 0;
    int quiet_cycles = 0;
    int send_pct = 34;
    int recv_pct = 50;
    int hold_asks = 0;
    int hold_served = 0;
    int hold_left = 0;

    fixed_block_free_list_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_req_type        (i_req_type),
        .i_free_index      (i_free_index),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_block_index     (o_block_index),
        .o_block_offset    (o_block_offset),
        .o_used_count      (o_used_count),
        .o_available_count (o_available_count),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic int pool_size();
        return (count_reg > POOL_MAX) ? POOL_MAX : int'(count_reg);
    endfunction

    function automatic int block_stride();
        int b;
        b = (bytes_reg > MAX_BLOCK_BYTES_DEF) ? MAX_BLOCK_BYTES_DEF : int'(bytes_reg);
        b = (b + 7) & ~7;
        return (b < 8) ? 8 : b;
    endfunction

    function automatic void rebuild_pool();
        int n;
        n = pool_size();
        for (int i = 0; i < POOL_MAX; i++)
            link_mem[i] = (i == 0) ? LINK_NIL : 9'(i - 1);
        list_head = (n == 0) ? LINK_NIL : 9'(n - 1);
        used_blocks = '0;
        held_blocks.delete();
    endfunction

    function automatic void apply_register(logic [1:0] ri, logic [12:0] data);
        if (ri == CFG_BLOCK_COUNT) begin
            count_reg = data[8:0];
            rebuild_pool();
        end else if (ri == CFG_BLOCK_BYTES) begin
            bytes_reg = data;
            rebuild_pool();
        end
    endfunction

    function automatic t_result serve_request(logic req, logic [7:0] idx);
        t_result r;
        int n;
        int hit [$];
        n = pool_size();
        r = '0;
        r.status = STS_OK;
        if (req == REQ_ALLOC) begin
            if (list_head >= POOL_MAX) begin
                r.status = STS_EMPTY;
            end else begin
                r.block_index = list_head[7:0];
                r.block_offset = 20'(int'(list_head) * block_stride());
                list_head = link_mem[list_head[7:0]];
                if (used_blocks != CNT_MAX) used_blocks++;
                held_blocks.push_back(r.block_index);
            end
        end else if (int'(idx) >= n) begin
            r.status = STS_RANGE;
        end else begin
            link_mem[idx] = list_head;
            list_head = {1'b0, idx};
            if (used_blocks != 0) used_blocks--;
            hit = held_blocks.find_first_index(x) with (x == idx);
            if (hit.size() != 0) held_blocks.delete(hit[0]);
        end
        r.used_count = used_blocks;
        r.available_count = (int'(used_blocks) >= n) ? 9'd0 : 9'(n - int'(used_blocks));
        return r;
    endfunction

    function automatic t_row req_row(logic req, logic [7:0] idx);
        t_row r;
        r.kind = ROW_REQ;
        r.req = req;
        r.idx = idx;
        r.reg_idx = CFG_BLOCK_COUNT;
        r.reg_data = '0;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic t_row chk_row(logic req, logic [7:0] idx, t_status st, logic [7:0] bi,
                                     logic [19:0] bo, logic [8:0] uc, logic [8:0] av);
        t_row r;
        r = req_row(req, idx);
        r.typed = 1'b1;
        r.want.status = st;
        r.want.block_index = bi;
        r.want.block_offset = bo;
        r.want.used_count = uc;
        r.want.available_count = av;
        return r;
    endfunction

    function automatic t_row reg_row(logic [1:0] ri, logic [12:0] data);
        t_row r;
        r = req_row(REQ_ALLOC, 8'd0);
        r.kind = ROW_REG;
        r.reg_idx = ri;
        r.reg_data = data;
        return r;
    endfunction

    function automatic void check_field(string name, int expv, int actv);
        if (expv != actv) begin
            $error("%s expected %0d got %0d", name, expv, actv);
            mismatches++;
        end
    endfunction

    task automatic send_request(logic req, logic [7:0] idx, bit typed, t_result want);
        t_result predicted;
        while ($urandom_range(0, 99) < send_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_free_index <= idx;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        predicted = serve_request(req, idx);
        owed_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (owed_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] ri, logic [12:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ri;
        i_cfg_data <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        apply_register(ri, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // receiver side: random stall, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_served != hold_asks) begin
            hold_served = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (owed_results.size() == 0) begin
                $error("result transfer with no request outstanding");
                mismatches++;
            end else begin
                due = owed_results.pop_front();
                check_field("status", due.status, o_status);
                check_field("block_index", due.block_index, o_block_index);
                check_field("block_offset", due.block_offset, o_block_offset);
                check_field("used_count", due.used_count, o_used_count);
                check_field("available_count", due.available_count, o_available_count);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("fixed_block_free_list_top verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int n;
        int roll;
        logic req;
        logic [7:0] idx;
        bit filling;
        t_row plan [$];

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        count_reg = BC_RESET;
        bytes_reg = BB_RESET;
        rebuild_pool();

        plan.push_back(chk_row(REQ_ALLOC, 8'd0, STS_OK, 8'd255, 20'd2040, 9'd1, 9'd255));
        plan.push_back(chk_row(REQ_FREE, 8'd255, STS_OK, 8'd0, 20'd0, 9'd0, 9'd256));
        // double free makes the head link to itself
        plan.push_back(req_row(REQ_FREE, 8'd255));
        plan.push_back(req_row(REQ_ALLOC, 8'd0));
        plan.push_back(req_row(REQ_ALLOC, 8'd0));
        plan.push_back(reg_row(CFG_BLOCK_BYTES, 13'd0));
        plan.push_back(chk_row(REQ_ALLOC, 8'd0, STS_OK, 8'd255, 20'd2040, 9'd1, 9'd255));
        plan.push_back(reg_row(CFG_BLOCK_BYTES, 13'h1FFF));
        plan.push_back(chk_row(REQ_ALLOC, 8'd0, STS_OK, 8'd255, 20'd1044480, 9'd1, 9'd255));
        plan.push_back(reg_row(CFG_BLOCK_BYTES, 13'd13));
        plan.push_back(chk_row(REQ_ALLOC, 8'd0, STS_OK, 8'd255, 20'd4080, 9'd1, 9'd255));
        plan.push_back(reg_row(CFG_SPARE, 13'd0));
        plan.push_back(req_row(REQ_ALLOC, 8'd0));
        plan.push_back(reg_row(CFG_BLOCK_COUNT, 13'd0));
        plan.push_back(chk_row(REQ_ALLOC, 8'd0, STS_EMPTY, 8'd0, 20'd0, 9'd0, 9'd0));
        plan.push_back(chk_row(REQ_FREE, 8'd0, STS_RANGE, 8'd0, 20'd0, 9'd0, 9'd0));
        plan.push_back(reg_row(CFG_BLOCK_COUNT, 13'h1FFF));
        plan.push_back(chk_row(REQ_ALLOC, 8'd0, STS_OK, 8'd255, 20'd4080, 9'd1, 9'd255));
        plan.push_back(reg_row(CFG_BLOCK_COUNT, 13'd1));
        plan.push_back(chk_row(REQ_ALLOC, 8'd0, STS_OK, 8'd0, 20'd0, 9'd1, 9'd0));
        plan.push_back(chk_row(REQ_ALLOC, 8'd0, STS_EMPTY, 8'd0, 20'd0, 9'd1, 9'd0));
        plan.push_back(chk_row(REQ_FREE, 8'd1, STS_RANGE, 8'd0, 20'd0, 9'd1, 9'd0));
        plan.push_back(chk_row(REQ_FREE, 8'd255, STS_RANGE, 8'd0, 20'd0, 9'd1, 9'd0));
        plan.push_back(chk_row(REQ_FREE, 8'd0, STS_OK, 8'd0, 20'd0, 9'd0, 9'd1));
        plan.push_back(chk_row(REQ_FREE, 8'd0, STS_OK, 8'd0, 20'd0, 9'd0, 9'd1));
        plan.push_back(req_row(REQ_ALLOC, 8'd0));
        plan.push_back(req_row(REQ_ALLOC, 8'd0));
        plan.push_back(reg_row(CFG_BLOCK_COUNT, 13'd256));
        plan.push_back(reg_row(CFG_BLOCK_BYTES, 13'd4096));
        plan.push_back(req_row(REQ_FREE, 8'd128));
        plan.push_back(req_row(REQ_ALLOC, 8'd0));

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_REG) begin
                drain();
                write_reg(plan[k].reg_idx, plan[k].reg_data);
            end else begin
                send_request(plan[k].req, plan[k].idx, plan[k].typed, plan[k].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p == 3) begin
                send_pct = 50;
                recv_pct = 34;
            end
            if (p == STORM_PHASE) begin
                send_pct = 0;
                recv_pct = 0;
            end
            drain();
            write_reg(CFG_BLOCK_COUNT, 13'(PH_COUNT[p]));
            write_reg(CFG_BLOCK_BYTES, 13'(PH_BYTES[p]));
            filling = 1'b1;
            for (int k = 0; k < PH_ITEMS[p]; k++) begin
                if (p == HOLD_PHASE && k == 100) hold_asks++;
                n = pool_size();
                roll = $urandom_range(0, 99);
                if (p == STORM_PHASE) begin
                    // alloc, free, free again closes a loop, then mostly allocs to drive the count toward saturation
                    req = (k == 0 || (k > 2 && roll < 97)) ? REQ_ALLOC : REQ_FREE;
                    idx = 8'd0;
                end else begin
                    if (list_head >= POOL_MAX) filling = 1'b0;
                    if (held_blocks.size() == 0) filling = 1'b1;
                    if (roll < 2) filling = !filling;
                    req = ($urandom_range(0, 99) < (filling ? 75 : 25)) ? REQ_ALLOC : REQ_FREE;
                    roll = $urandom_range(0, 99);
                    if (roll < 85 && held_blocks.size() != 0)
                        idx = held_blocks[$urandom_range(0, held_blocks.size() - 1)];
                    else if (roll < 92 && n != 0)
                        idx = 8'($urandom_range(0, n - 1));
                    else
                        idx = 8'($urandom);
                end
                send_request(req, idx, 1'b0, '0);
            end
        end

        drain();
        repeat (16) @(negedge i_clk);
        if (mismatches == 0)
            $display("fixed_block_free_list_top verification clean");
        else
            $display("fixed_block_free_list_top verification failed");
        $finish;
    end

endmodule

// File: files.f
hdl/fbfl_pkg.sv
hdl/fbfl_ram.sv
hdl/fbfl_ctrl.sv
hdl/fbfl_out_fifo.sv
hdl/fixed_block_free_list_top.sv
sim/testbench.sv
